// File: hw/rtl/tlsf_pkg.sv
// Shared types, codes and reset constants for the tunnel link setup block.
package tlsf_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        FN_START   = 3'd0,
        FN_TICK    = 3'd1,
        FN_REPLY   = 3'd2,
        FN_OPEN    = 3'd3,
        FN_MESSAGE = 3'd4,
        FN_COMMAND = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        ACT_REQUIRE   = 3'd0,
        ACT_ACK_OK    = 3'd1,
        ACT_NO_DEVICE = 3'd2,
        ACT_OFFLINE   = 3'd3
    } t_act;

    typedef enum logic [1:0] {
        PH_APPLYING = 2'd0,
        PH_CREATING = 2'd1,
        PH_FOUND    = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        SEND_NONE    = 2'd0,
        SEND_REQUEST = 2'd1,
        SEND_OPEN    = 2'd2,
        SEND_COMMAND = 2'd3
    } t_send;

    typedef enum logic [1:0] {
        ST_SUCCESS     = 2'd0,
        ST_NOT_STARTED = 2'd1,
        ST_LINKING     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        EX_NONE       = 3'd0,
        EX_RELAY_LOST = 3'd1,
        EX_PEER_LOST  = 3'd2,
        EX_NO_NAME    = 3'd3,
        EX_OFFLINE    = 3'd4,
        EX_BUSY       = 3'd5,
        EX_UNKNOWN    = 3'd6
    } t_exit;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_CONNECTED = 2'd1,
        EV_FAILED    = 2'd2
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECT_MODE   = 3'd0,
        CFG_START_ADDR    = 3'd1,
        CFG_START_PORT    = 3'd2,
        CFG_MAX_REQUEST   = 3'd3,
        CFG_MAX_OPEN      = 3'd4,
        CFG_MAX_IDLE      = 3'd5,
        CFG_KEEPALIVE     = 3'd6
    } t_cfg_idx;

    localparam logic [7:0] RST_MAX_REQUEST = 8'd10;
    localparam logic [7:0] RST_MAX_OPEN    = 8'd10;
    localparam logic [7:0] RST_MAX_IDLE    = 8'd30;
    localparam logic [7:0] RST_KEEPALIVE   = 8'd5;

    typedef struct packed {
        logic        direct_mode;
        logic [31:0] start_addr;
        logic [15:0] start_port;
        logic [7:0]  max_request_retries;
        logic [7:0]  max_open_retries;
        logic [7:0]  max_idle_ticks;
        logic [7:0]  keepalive_ticks;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  func;
        logic [2:0]  act_code;
        logic        name_matches;
        logic [31:0] peer_addr;
        logic [15:0] peer_port;
    } t_item;

    typedef struct packed {
        t_send       send_kind;
        logic [31:0] dest_addr;
        logic [15:0] dest_port;
        logic        alive;
        t_status     cmd_status;
        t_exit       exit_reason;
        t_event      connect_event;
        logic [2:0]  reply_act;
        logic        deliver;
        logic        payload_live;
        t_phase      link_phase;
    } t_result;

    function automatic logic [7:0] inc_sat(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

endpackage

// File: hw/rtl/tlsf_cfg_regs.sv
// Configuration register file for the tunnel link setup block.
module tlsf_cfg_regs
    import tlsf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direct_mode         <= 1'b0;
            r_cfg.start_addr          <= '0;
            r_cfg.start_port          <= '0;
            r_cfg.max_request_retries <= RST_MAX_REQUEST;
            r_cfg.max_open_retries    <= RST_MAX_OPEN;
            r_cfg.max_idle_ticks      <= RST_MAX_IDLE;
            r_cfg.keepalive_ticks     <= RST_KEEPALIVE;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DIRECT_MODE: r_cfg.direct_mode         <= i_cfg_data[0];
                CFG_START_ADDR:  r_cfg.start_addr          <= i_cfg_data[31:0];
                CFG_START_PORT:  r_cfg.start_port          <= i_cfg_data[15:0];
                CFG_MAX_REQUEST: r_cfg.max_request_retries <= i_cfg_data[7:0];
                CFG_MAX_OPEN:    r_cfg.max_open_retries    <= i_cfg_data[7:0];
                CFG_MAX_IDLE:    r_cfg.max_idle_ticks      <= i_cfg_data[7:0];
                CFG_KEEPALIVE:   r_cfg.keepalive_ticks     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/tlsf_in_stage.sv
// Input register stage: holds one accepted word until the engine takes it.
module tlsf_in_stage
    import tlsf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_item_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

// File: hw/rtl/tlsf_engine.sv
// Link state registers, per-word next-state logic and the result register.
module tlsf_engine
    import tlsf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_item_valid,
    input  t_item   i_item,
    output logic    o_take,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    t_phase      r_phase,   n_phase;
    logic        r_started, n_started;
    logic        r_hopeless, n_hopeless;
    logic        r_reported, n_reported;
    logic [7:0]  r_req_cnt, n_req_cnt;
    logic [7:0]  r_open_cnt, n_open_cnt;
    logic [7:0]  r_idle_cnt, n_idle_cnt;
    logic [7:0]  r_ka_cnt,  n_ka_cnt;
    logic [31:0] r_peer_addr, n_peer_addr;
    logic [15:0] r_peer_port, n_peer_port;
    t_exit       r_last_exit, n_last_exit;
    logic        r_live,    n_live;

    logic        r_out_valid;
    t_result     r_res;
    t_result     n_res;

    assign o_take = i_item_valid && (!r_out_valid || i_ready);

    always_comb begin
        n_phase     = r_phase;
        n_started   = r_started;
        n_hopeless  = r_hopeless;
        n_reported  = r_reported;
        n_req_cnt   = r_req_cnt;
        n_open_cnt  = r_open_cnt;
        n_idle_cnt  = r_idle_cnt;
        n_ka_cnt    = r_ka_cnt;
        n_peer_addr = r_peer_addr;
        n_peer_port = r_peer_port;
        n_last_exit = r_last_exit;
        n_live      = r_live;

        n_res               = '0;
        n_res.send_kind     = SEND_NONE;
        n_res.alive         = 1'b1;
        n_res.cmd_status    = ST_SUCCESS;
        n_res.connect_event = EV_NONE;

        case (i_item.func)
            FN_COMMAND: begin
                if (!r_started) begin
                    n_res.cmd_status = ST_NOT_STARTED;
                    n_res.alive      = 1'b0;
                end else if (r_phase != PH_FOUND) begin
                    n_res.cmd_status = ST_LINKING;
                    n_res.alive      = 1'b0;
                end else begin
                    n_live          = 1'b0;
                    n_res.send_kind = SEND_COMMAND;
                    n_res.dest_addr = r_peer_addr;
                    n_res.dest_port = r_peer_port;
                end
            end
            FN_START: begin
                if (!r_started) begin
                    n_started   = 1'b1;
                    n_hopeless  = 1'b0;
                    n_reported  = 1'b0;
                    n_live      = 1'b0;
                    n_req_cnt   = '0;
                    n_open_cnt  = '0;
                    n_idle_cnt  = '0;
                    n_ka_cnt    = '0;
                    n_last_exit = EX_NONE;
                    n_res.dest_addr = i_cfg.start_addr;
                    n_res.dest_port = i_cfg.start_port;
                    if (i_cfg.direct_mode) begin
                        n_phase         = PH_FOUND;
                        n_peer_addr     = i_cfg.start_addr;
                        n_peer_port     = i_cfg.start_port;
                        n_res.send_kind = SEND_COMMAND;
                    end else begin
                        n_phase         = PH_APPLYING;
                        n_res.send_kind = SEND_REQUEST;
                    end
                end
            end
            default: begin
                if (r_started) begin
                    case (i_item.func)
                        FN_TICK: begin
                            if (r_hopeless) begin
                                n_res.alive = 1'b0;
                            end else begin
                                case (r_phase)
                                    PH_APPLYING: begin
                                        if (r_req_cnt > i_cfg.max_request_retries) begin
                                            n_last_exit         = EX_RELAY_LOST;
                                            n_res.connect_event = EV_FAILED;
                                            n_res.alive         = 1'b0;
                                        end else begin
                                            n_req_cnt       = inc_sat(r_req_cnt);
                                            n_res.send_kind = SEND_REQUEST;
                                            n_res.dest_addr = i_cfg.start_addr;
                                            n_res.dest_port = i_cfg.start_port;
                                        end
                                    end
                                    PH_CREATING: begin
                                        if (r_open_cnt > i_cfg.max_open_retries) begin
                                            n_last_exit         = EX_PEER_LOST;
                                            n_res.connect_event = EV_FAILED;
                                            n_res.alive         = 1'b0;
                                        end else begin
                                            n_open_cnt      = inc_sat(r_open_cnt);
                                            n_res.send_kind = SEND_OPEN;
                                            n_res.dest_addr = r_peer_addr;
                                            n_res.dest_port = r_peer_port;
                                        end
                                    end
                                    default: begin
                                        if (r_idle_cnt > i_cfg.max_idle_ticks) begin
                                            n_last_exit = EX_PEER_LOST;
                                            n_res.alive = 1'b0;
                                        end else begin
                                            n_idle_cnt = inc_sat(r_idle_cnt);
                                            if (r_ka_cnt >= i_cfg.keepalive_ticks) begin
                                                n_res.send_kind    = SEND_COMMAND;
                                                n_res.dest_addr    = r_peer_addr;
                                                n_res.dest_port    = r_peer_port;
                                                n_res.payload_live = r_live;
                                                n_ka_cnt           = '0;
                                            end else begin
                                                n_ka_cnt = inc_sat(r_ka_cnt);
                                            end
                                        end
                                    end
                                endcase
                            end
                        end
                        FN_REPLY: begin
                            if (r_phase == PH_APPLYING) begin
                                if (i_item.act_code != ACT_ACK_OK) begin
                                    case (i_item.act_code)
                                        ACT_NO_DEVICE: n_last_exit = EX_NO_NAME;
                                        ACT_OFFLINE:   n_last_exit = EX_OFFLINE;
                                        default:       n_last_exit = EX_BUSY;
                                    endcase
                                    n_hopeless  = 1'b1;
                                    n_res.alive = 1'b0;
                                end else if (!i_item.name_matches) begin
                                    n_last_exit = EX_UNKNOWN;
                                    n_res.alive = 1'b0;
                                end else begin
                                    n_peer_addr     = i_item.peer_addr;
                                    n_peer_port     = i_item.peer_port;
                                    n_phase         = PH_CREATING;
                                    n_res.send_kind = SEND_OPEN;
                                    n_res.dest_addr = i_item.peer_addr;
                                    n_res.dest_port = i_item.peer_port;
                                end
                            end
                        end
                        FN_OPEN: begin
                            if (r_phase == PH_FOUND) begin
                                n_res.reply_act = ACT_ACK_OK;
                            end else if (i_item.act_code != ACT_REQUIRE &&
                                         i_item.act_code != ACT_ACK_OK) begin
                                // peer refuses: echo its code back
                                n_hopeless      = 1'b1;
                                n_last_exit     = EX_BUSY;
                                n_res.reply_act = i_item.act_code;
                                n_res.alive     = 1'b0;
                            end else begin
                                n_peer_addr        = i_item.peer_addr;
                                n_peer_port        = i_item.peer_port;
                                n_phase            = PH_FOUND;
                                n_res.send_kind    = SEND_COMMAND;
                                n_res.dest_addr    = i_item.peer_addr;
                                n_res.dest_port    = i_item.peer_port;
                                n_res.payload_live = r_live;
                                n_res.reply_act    = ACT_ACK_OK;
                            end
                        end
                        FN_MESSAGE: begin
                            if (r_phase != PH_FOUND || !i_item.name_matches) begin
                                n_res.alive = 1'b0;
                            end else begin
                                if (!r_reported) begin
                                    n_res.connect_event = EV_CONNECTED;
                                    n_reported          = 1'b1;
                                end
                                n_idle_cnt    = '0;
                                n_ka_cnt      = '0;
                                n_live        = 1'b1;
                                n_res.deliver = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        endcase

        n_res.exit_reason = n_last_exit;
        n_res.link_phase  = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_APPLYING;
            r_started   <= 1'b0;
            r_hopeless  <= 1'b0;
            r_reported  <= 1'b0;
            r_req_cnt   <= '0;
            r_open_cnt  <= '0;
            r_idle_cnt  <= '0;
            r_ka_cnt    <= '0;
            r_peer_addr <= '0;
            r_peer_port <= '0;
            r_last_exit <= EX_NONE;
            r_live      <= 1'b0;
        end else if (o_take) begin
            r_phase     <= n_phase;
            r_started   <= n_started;
            r_hopeless  <= n_hopeless;
            r_reported  <= n_reported;
            r_req_cnt   <= n_req_cnt;
            r_open_cnt  <= n_open_cnt;
            r_idle_cnt  <= n_idle_cnt;
            r_ka_cnt    <= n_ka_cnt;
            r_peer_addr <= n_peer_addr;
            r_peer_port <= n_peer_port;
            r_last_exit <= n_last_exit;
            r_live      <= n_live;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= i_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

endmodule

// File: hw/rtl/tunnel_link_setup_fsm.sv
// Tunnel link setup: client-side handshake state machine, one word in, one result out.
// Takes one word per clock when the result side keeps up. A word is registered on
// acceptance and evaluated against the link state while it waits in the input register;
// the result register and the link state load together when the engine takes the word,
// which a stalled result holds off, so o_valid rises with the result and each word
// sees the state left by the one before.
// A stalled result holds in the output register while one more word waits in the input
// register. Configuration writes take effect at once and belong to idle periods.
module tunnel_link_setup_fsm
    import tlsf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_func,
    input  logic [2:0]            i_act_code,
    input  logic                  i_name_matches,
    input  logic [31:0]           i_peer_addr,
    input  logic [15:0]           i_peer_port,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_send_kind,
    output logic [31:0]           o_dest_addr,
    output logic [15:0]           o_dest_port,
    output logic                  o_alive,
    output logic [1:0]            o_cmd_status,
    output logic [2:0]            o_exit_reason,
    output logic [1:0]            o_connect_event,
    output logic [2:0]            o_reply_act,
    output logic                  o_deliver,
    output logic                  o_payload_live,
    output logic [1:0]            o_link_phase
);

    t_cfg    cfg;
    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    take;
    t_result res;

    assign in_item.func         = i_func;
    assign in_item.act_code     = i_act_code;
    assign in_item.name_matches = i_name_matches;
    assign in_item.peer_addr    = i_peer_addr;
    assign in_item.peer_port    = i_peer_port;

    tlsf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tlsf_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (in_item),
        .i_take       (take),
        .o_item_valid (stage_valid),
        .o_item       (stage_item)
    );

    tlsf_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (stage_valid),
        .i_item       (stage_item),
        .o_take       (take),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_res        (res)
    );

    assign o_send_kind     = res.send_kind;
    assign o_dest_addr     = res.dest_addr;
    assign o_dest_port     = res.dest_port;
    assign o_alive         = res.alive;
    assign o_cmd_status    = res.cmd_status;
    assign o_exit_reason   = res.exit_reason;
    assign o_connect_event = res.connect_event;
    assign o_reply_act     = res.reply_act;
    assign o_deliver       = res.deliver;
    assign o_payload_live  = res.payload_live;
    assign o_link_phase    = res.link_phase;

endmodule

// File: hw/rtl/tlsf_checker.sv
// Port-level checker for the tunnel link setup block, bound to the top level.
module tlsf_checker
    import tlsf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_send_kind,
    input logic [31:0] o_dest_addr,
    input logic [15:0] o_dest_port,
    input logic        o_alive,
    input logic [1:0]  o_cmd_status,
    input logic        o_deliver,
    input logic [1:0]  o_link_phase
);

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_send_kind) && $stable(o_dest_addr)
            && $stable(o_dest_port) && $stable(o_alive))
        else $error("result changed while stalled");

    a_no_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_send_kind == SEND_NONE |-> o_dest_addr == '0 && o_dest_port == '0)
        else $error("destination set with nothing to send");

    a_cmd_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cmd_status != ST_SUCCESS |-> !o_alive && o_send_kind == SEND_NONE)
        else $error("failed command request still sends or lives");

    a_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_deliver |-> o_alive && o_link_phase == PH_FOUND)
        else $error("message delivered outside found phase");

endmodule

bind tunnel_link_setup_fsm tlsf_checker u_tlsf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_send_kind  (o_send_kind),
    .o_dest_addr  (o_dest_addr),
    .o_dest_port  (o_dest_port),
    .o_alive      (o_alive),
    .o_cmd_status (o_cmd_status),
    .o_deliver    (o_deliver),
    .o_link_phase (o_link_phase)
);

// File: tb/tunnel_link_setup_fsm_tb.sv
// Self-checking testbench for the tunnel link setup state machine.
module tunnel_link_setup_fsm_tb;
    import tlsf_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_REPORTS = 40;

    localparam logic [2:0] FN_SPARE_6    = 3'd6;
    localparam logic [2:0] FN_SPARE_7    = 3'd7;
    localparam logic [2:0] ACT_DUPLICATE = 3'd4;

    typedef enum {RUN_RELAY, RUN_DIRECT, RUN_REPLY_REFUSED, RUN_OPEN_REFUSED} t_run_kind;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_valid        = 1'b0;
    logic                  o_ready;
    logic [2:0]            i_func         = '0;
    logic [2:0]            i_act_code     = '0;
    logic                  i_name_matches = 1'b0;
    logic [31:0]           i_peer_addr    = '0;
    logic [15:0]           i_peer_port    = '0;
    logic                  o_valid;
    logic                  i_ready        = 1'b1;
    logic [1:0]            o_send_kind;
    logic [31:0]           o_dest_addr;
    logic [15:0]           o_dest_port;
    logic                  o_alive;
    logic [1:0]            o_cmd_status;
    logic [2:0]            o_exit_reason;
    logic [1:0]            o_connect_event;
    logic [2:0]            o_reply_act;
    logic                  o_deliver;
    logic                  o_payload_live;
    logic [1:0]            o_link_phase;

    tunnel_link_setup_fsm dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_act_code      (i_act_code),
        .i_name_matches  (i_name_matches),
        .i_peer_addr     (i_peer_addr),
        .i_peer_port     (i_peer_port),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_send_kind     (o_send_kind),
        .o_dest_addr     (o_dest_addr),
        .o_dest_port     (o_dest_port),
        .o_alive         (o_alive),
        .o_cmd_status    (o_cmd_status),
        .o_exit_reason   (o_exit_reason),
        .o_connect_event (o_connect_event),
        .o_reply_act     (o_reply_act),
        .o_deliver       (o_deliver),
        .o_payload_live  (o_payload_live),
        .o_link_phase    (o_link_phase)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // link state as the block should hold it
    t_cfg        cfg_now = '{1'b0, 32'd0, 16'd0, RST_MAX_REQUEST, RST_MAX_OPEN,
                             RST_MAX_IDLE, RST_KEEPALIVE};
    t_phase      lk_phase    = PH_APPLYING;
    t_exit       lk_exit     = EX_NONE;
    logic        lk_started  = 1'b0;
    logic        lk_hopeless = 1'b0;
    logic        lk_reported = 1'b0;
    logic        lk_live     = 1'b0;
    logic [7:0]  lk_req_cnt  = '0;
    logic [7:0]  lk_open_cnt = '0;
    logic [7:0]  lk_idle_cnt = '0;
    logic [7:0]  lk_ka_cnt   = '0;
    logic [47:0] lk_peer     = '0;

    t_item     word_q[$];
    t_result   link_result_q[$];
    t_item     held_word;
    t_result   want;
    t_run_kind run_kind;
    int        send_idle_pct   = 0;
    int        recv_stall_pct  = 0;
    int        words_sent      = 0;
    int        results_checked = 0;
    int        mismatches      = 0;
    int        quiet_cycles    = 0;

    function automatic logic [7:0] count_up(input logic [7:0] v);
        return v + {7'd0, ~&v};
    endfunction

    function automatic t_result predict_link_result(input t_item w);
        t_result     r;
        logic [47:0] relay;
        relay = {cfg_now.start_addr, cfg_now.start_port};
        r = '0;
        r.alive = 1'b1;
        if (w.func == FN_COMMAND) begin
            if (!lk_started) begin
                r.cmd_status = ST_NOT_STARTED;
                r.alive = 1'b0;
            end else if (lk_phase != PH_FOUND) begin
                r.cmd_status = ST_LINKING;
                r.alive = 1'b0;
            end else begin
                lk_live = 1'b0;
                r.send_kind = SEND_COMMAND;
                {r.dest_addr, r.dest_port} = lk_peer;
            end
        end else if (w.func == FN_START) begin
            if (!lk_started) begin
                lk_started  = 1'b1;
                lk_hopeless = 1'b0;
                lk_reported = 1'b0;
                lk_live     = 1'b0;
                lk_req_cnt  = '0;
                lk_open_cnt = '0;
                lk_idle_cnt = '0;
                lk_ka_cnt   = '0;
                lk_exit     = EX_NONE;
                if (cfg_now.direct_mode) begin
                    lk_phase = PH_FOUND;
                    lk_peer = relay;
                    r.send_kind = SEND_COMMAND;
                end else begin
                    lk_phase = PH_APPLYING;
                    r.send_kind = SEND_REQUEST;
                end
                {r.dest_addr, r.dest_port} = relay;
            end
        end else if (!lk_started || w.func > FN_COMMAND) begin
            // nothing to do before start, spare codes always ignored
        end else if (w.func == FN_TICK) begin
            if (lk_hopeless) begin
                r.alive = 1'b0;
            end else if (lk_phase == PH_APPLYING) begin
                if (lk_req_cnt > cfg_now.max_request_retries) begin
                    lk_exit = EX_RELAY_LOST;
                    r.connect_event = EV_FAILED;
                    r.alive = 1'b0;
                end else begin
                    lk_req_cnt = count_up(lk_req_cnt);
                    r.send_kind = SEND_REQUEST;
                    {r.dest_addr, r.dest_port} = relay;
                end
            end else if (lk_phase == PH_CREATING) begin
                if (lk_open_cnt > cfg_now.max_open_retries) begin
                    lk_exit = EX_PEER_LOST;
                    r.connect_event = EV_FAILED;
                    r.alive = 1'b0;
                end else begin
                    lk_open_cnt = count_up(lk_open_cnt);
                    r.send_kind = SEND_OPEN;
                    {r.dest_addr, r.dest_port} = lk_peer;
                end
            end else begin
                if (lk_idle_cnt > cfg_now.max_idle_ticks) begin
                    lk_exit = EX_PEER_LOST;
                    r.alive = 1'b0;
                end else begin
                    lk_idle_cnt = count_up(lk_idle_cnt);
                    if (lk_ka_cnt >= cfg_now.keepalive_ticks) begin
                        r.send_kind = SEND_COMMAND;
                        {r.dest_addr, r.dest_port} = lk_peer;
                        r.payload_live = lk_live;
                        lk_ka_cnt = '0;
                    end else begin
                        lk_ka_cnt = count_up(lk_ka_cnt);
                    end
                end
            end
        end else if (w.func == FN_REPLY) begin
            if (lk_phase == PH_APPLYING) begin
                if (w.act_code != ACT_ACK_OK) begin
                    lk_exit = (w.act_code == ACT_NO_DEVICE) ? EX_NO_NAME :
                              (w.act_code == ACT_OFFLINE) ? EX_OFFLINE : EX_BUSY;
                    lk_hopeless = 1'b1;
                    r.alive = 1'b0;
                end else if (!w.name_matches) begin
                    lk_exit = EX_UNKNOWN;
                    r.alive = 1'b0;
                end else begin
                    lk_peer = {w.peer_addr, w.peer_port};
                    lk_phase = PH_CREATING;
                    r.send_kind = SEND_OPEN;
                    {r.dest_addr, r.dest_port} = lk_peer;
                end
            end
        end else if (w.func == FN_OPEN) begin
            if (lk_phase == PH_FOUND) begin
                r.reply_act = ACT_ACK_OK;
            end else if (w.act_code != ACT_REQUIRE && w.act_code != ACT_ACK_OK) begin
                lk_hopeless = 1'b1;
                lk_exit = EX_BUSY;
                r.reply_act = w.act_code;
                r.alive = 1'b0;
            end else begin
                lk_peer = {w.peer_addr, w.peer_port};
                lk_phase = PH_FOUND;
                r.send_kind = SEND_COMMAND;
                {r.dest_addr, r.dest_port} = lk_peer;
                r.payload_live = lk_live;
                r.reply_act = ACT_ACK_OK;
            end
        end else begin
            if (lk_phase != PH_FOUND || !w.name_matches) begin
                r.alive = 1'b0;
            end else begin
                if (!lk_reported) begin
                    r.connect_event = EV_CONNECTED;
                    lk_reported = 1'b1;
                end
                lk_idle_cnt = '0;
                lk_ka_cnt = '0;
                lk_live = 1'b1;
                r.deliver = 1'b1;
            end
        end
        r.exit_reason = lk_exit;
        r.link_phase = lk_phase;
        return r;
    endfunction

    // driver: offers the next queued word, predicts each accepted one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                link_result_q.push_back(predict_link_result(held_word));
                words_sent++;
            end
            if (!i_valid || o_ready) begin
                if (word_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    held_word = word_q.pop_front();
                    {i_func, i_act_code, i_name_matches, i_peer_addr, i_peer_port} <= held_word;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string fname, input logic [47:0] exp_v,
                               input logic [47:0] act_v);
        if (act_v !== exp_v) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, exp_v, act_v);
        end
    endtask

    // monitor: random back-pressure, compares each result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (o_valid && i_ready) begin
                if (link_result_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, got kind %0h alive %0h",
                                 $time, o_send_kind, o_alive);
                end else begin
                    want = link_result_q.pop_front();
                    results_checked++;
                    check_field("send_kind", 48'(want.send_kind), 48'(o_send_kind));
                    check_field("dest_addr", 48'(want.dest_addr), 48'(o_dest_addr));
                    check_field("dest_port", 48'(want.dest_port), 48'(o_dest_port));
                    check_field("alive", 48'(want.alive), 48'(o_alive));
                    check_field("cmd_status", 48'(want.cmd_status), 48'(o_cmd_status));
                    check_field("exit_reason", 48'(want.exit_reason), 48'(o_exit_reason));
                    check_field("connect_event", 48'(want.connect_event),
                                48'(o_connect_event));
                    check_field("reply_act", 48'(want.reply_act), 48'(o_reply_act));
                    check_field("deliver", 48'(want.deliver), 48'(o_deliver));
                    check_field("payload_live", 48'(want.payload_live), 48'(o_payload_live));
                    check_field("link_phase", 48'(want.link_phase), 48'(o_link_phase));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("tunnel_link_setup_fsm test failed");
        $finish;
    end

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic push_word(input logic [2:0] f, input logic [2:0] act, input logic nm,
                             input logic [31:0] addr, input logic [15:0] port);
        word_q.push_back(t_item'({f, act, nm, addr, port}));
    endtask

    task automatic wait_link_idle();
        while (word_q.size() != 0 || i_valid || link_result_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
    endtask

    task automatic load_link_config(input t_cfg c);
        wait_link_idle();
        write_reg(CFG_DIRECT_MODE, CFG_DATA_W'(c.direct_mode));
        write_reg(CFG_START_ADDR, CFG_DATA_W'(c.start_addr));
        write_reg(CFG_START_PORT, CFG_DATA_W'(c.start_port));
        write_reg(CFG_MAX_REQUEST, CFG_DATA_W'(c.max_request_retries));
        write_reg(CFG_MAX_OPEN, CFG_DATA_W'(c.max_open_retries));
        write_reg(CFG_MAX_IDLE, CFG_DATA_W'(c.max_idle_ticks));
        write_reg(CFG_KEEPALIVE, CFG_DATA_W'(c.keepalive_ticks));
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_now = c;
        @(negedge i_clk);
    endtask

    // mostly ticks plus items that neither advance the phase nor give up the link
    task automatic queue_pre_link_noise(input int n);
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                push_word(FN_TICK, 3'($urandom_range(0, 7)), 1'($urandom), pick_addr(), pick_port());
            else if (pick < 82)
                push_word(FN_COMMAND, 3'($urandom_range(0, 7)), 1'($urandom), pick_addr(), pick_port());
            else if (pick < 89)
                push_word(FN_MESSAGE, 3'($urandom_range(0, 7)), 1'($urandom), pick_addr(), pick_port());
            else if (pick < 94)
                push_word(FN_REPLY, ACT_ACK_OK, 1'b0, pick_addr(), pick_port());
            else if (pick < 97)
                push_word(FN_START, 3'($urandom_range(0, 7)), 1'($urandom), pick_addr(), pick_port());
            else
                push_word(pick[0] ? FN_SPARE_7 : FN_SPARE_6, 3'($urandom_range(0, 7)),
                          1'($urandom), pick_addr(), pick_port());
        end
    endtask

    task automatic queue_found_traffic(input int n);
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 48)
                push_word(FN_TICK, 3'($urandom_range(0, 7)), 1'($urandom), pick_addr(), pick_port());
            else if (pick < 68)
                push_word(FN_MESSAGE, 3'($urandom_range(0, 7)), ($urandom_range(0, 7) != 0),
                          pick_addr(), pick_port());
            else if (pick < 77)
                push_word(FN_COMMAND, 3'($urandom_range(0, 7)), 1'($urandom), pick_addr(), pick_port());
            else if (pick < 84)
                push_word(FN_OPEN, 3'($urandom_range(0, 7)), 1'($urandom), pick_addr(), pick_port());
            else if (pick < 90)
                push_word(FN_REPLY, 3'($urandom_range(0, 7)), 1'($urandom), pick_addr(), pick_port());
            else if (pick < 94)
                push_word(FN_START, 3'($urandom_range(0, 7)), 1'($urandom), pick_addr(), pick_port());
            else
                push_word(pick[0] ? FN_SPARE_7 : FN_SPARE_6, 3'($urandom_range(0, 7)),
                          1'($urandom), pick_addr(), pick_port());
        end
    endtask

    initial begin
        t_cfg c;
        case ($urandom_range(0, 7))
            0: run_kind = RUN_DIRECT;
            1: run_kind = RUN_REPLY_REFUSED;
            2: run_kind = RUN_OPEN_REFUSED;
            default: run_kind = RUN_RELAY;
        endcase

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        c = '{(run_kind == RUN_DIRECT), 32'hFFFF_FFFF, 16'h0000, 8'd2, 8'd1, 8'd30, 8'd5};
        load_link_config(c);

        // before start only a command request is answered
        push_word(FN_COMMAND, ACT_REQUIRE, 1'b1, pick_addr(), pick_port());
        push_word(FN_TICK, ACT_REQUIRE, 1'b0, pick_addr(), pick_port());
        push_word(FN_REPLY, ACT_ACK_OK, 1'b1, pick_addr(), pick_port());
        push_word(FN_OPEN, ACT_REQUIRE, 1'b1, pick_addr(), pick_port());
        push_word(FN_MESSAGE, ACT_ACK_OK, 1'b1, pick_addr(), pick_port());
        push_word(FN_SPARE_6, ACT_DUPLICATE, 1'b0, pick_addr(), pick_port());
        push_word(FN_START, ACT_REQUIRE, 1'b0, 32'd0, 16'd0);
        push_word(FN_START, ACT_OFFLINE, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        push_word(FN_COMMAND, ACT_REQUIRE, 1'b1, pick_addr(), pick_port());
        push_word(FN_MESSAGE, ACT_REQUIRE, 1'b1, pick_addr(), pick_port());
        // limit of two: the fourth tick expires the relay request
        repeat (4) push_word(FN_TICK, ACT_REQUIRE, 1'b1, pick_addr(), pick_port());
        push_word(FN_REPLY, ACT_ACK_OK, 1'b0, pick_addr(), pick_port());

        // count saturates at the top limit and must never expire
        c.max_request_retries = 8'hFF;
        c.start_addr = 32'd0;
        c.start_port = 16'hFFFF;
        load_link_config(c);
        send_idle_pct = 65;
        queue_pre_link_noise(270);
        wait_link_idle();
        send_idle_pct = 0;

        if (run_kind == RUN_REPLY_REFUSED) begin
            // 1..7 plus one wraps to every refusing code, require included
            push_word(FN_REPLY, 3'($urandom_range(1, 7)) + 3'd1, 1'b1, pick_addr(), pick_port());
            push_word(FN_TICK, ACT_REQUIRE, 1'b1, pick_addr(), pick_port());
        end
        push_word(FN_REPLY, ACT_ACK_OK, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        push_word(FN_REPLY, ACT_ACK_OK, 1'b1, pick_addr(), pick_port());
        push_word(FN_COMMAND, ACT_REQUIRE, 1'b0, pick_addr(), pick_port());
        repeat (3) push_word(FN_TICK, ACT_REQUIRE, 1'b0, pick_addr(), pick_port());
        if (run_kind == RUN_OPEN_REFUSED)
            push_word(FN_OPEN, 3'($urandom_range(2, 7)), 1'b1, pick_addr(), pick_port());

        c.max_open_retries = 8'hFF;
        c.direct_mode = ~c.direct_mode;
        load_link_config(c);
        recv_stall_pct = 65;
        queue_pre_link_noise(270);
        wait_link_idle();
        recv_stall_pct = 0;

        push_word(FN_OPEN, ACT_REQUIRE, 1'b0, 32'd0, 16'd0);
        push_word(FN_MESSAGE, ACT_REQUIRE, 1'b1, pick_addr(), pick_port());
        push_word(FN_MESSAGE, ACT_ACK_OK, 1'b1, pick_addr(), pick_port());
        push_word(FN_COMMAND, ACT_REQUIRE, 1'b1, pick_addr(), pick_port());

        for (int seg = 0; seg < 4; seg++) begin
            c.direct_mode = 1'($urandom);
            c.start_addr = pick_addr();
            c.start_port = pick_port();
            c.max_request_retries = 8'($urandom_range(0, 255));
            c.max_open_retries = 8'($urandom_range(0, 255));
            case (seg)
                0: begin
                    c.max_idle_ticks = 8'd0;
                    c.keepalive_ticks = 8'd0;
                end
                1: begin
                    c.max_idle_ticks = 8'hFF;
                    c.keepalive_ticks = 8'hFF;
                end
                2: begin
                    c.max_idle_ticks = 8'($urandom_range(1, 12));
                    c.keepalive_ticks = 8'($urandom_range(0, 6));
                end
                default: begin
                    c.max_idle_ticks = 8'($urandom_range(0, 40));
                    c.keepalive_ticks = 8'($urandom_range(0, 20));
                end
            endcase
            load_link_config(c);
            case (seg)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            queue_found_traffic(330);
        end

        wait_link_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Run: %0d words, %s start, applying/creating/found with four flow-control mixes.",
                 words_sent, run_kind.name());
        $display("Results compared: %0d, mismatches: %0d.", results_checked, mismatches);
        if (mismatches == 0)
            $display("tunnel_link_setup_fsm test passed");
        else
            $display("tunnel_link_setup_fsm test failed");
        $finish;
    end

endmodule
